>>> design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> design/tama_pkg.sv
`timescale 1ns / 1ps

package tama_pkg;

   localparam int WINDOW   = 16;
   localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SAMPLE_W = 16;
   localparam int MEAN_W   = 20;
   // exact window sum: sample width plus growth over the window
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);

   typedef logic [PTR_W-1:0] ptr_type;

   // control shared by all lanes for one accepted word
   typedef struct packed {
      logic    accept;
      logic    primed;  // ring has wrapped at least once
      ptr_type ptr;
   } lane_ctl_type;

   typedef struct packed {
      logic                     mean_valid;
      logic signed [MEAN_W-1:0] mean_x;
      logic signed [MEAN_W-1:0] mean_y;
      logic signed [MEAN_W-1:0] mean_z;
   } result_type;

endpackage

>>> design/tama_lane.sv
`timescale 1ns / 1ps

module tama_lane (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tama_pkg::lane_ctl_type                 ctl,
   input  logic signed [tama_pkg::SAMPLE_W-1:0]   sample,
   output logic signed [tama_pkg::SUM_W-1:0]      sum_next
);
   import tama_pkg::*;

   logic signed [SAMPLE_W-1:0] ring_ff [WINDOW];
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [SAMPLE_W-1:0] oldest;

   // entries not yet written since reset read as zero
   assign oldest = ctl.primed ? ring_ff[ctl.ptr] : '0;
   assign sum_in = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
   assign sum_next = sum_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctl.accept) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         ring_ff[ctl.ptr] <= sample;
      end
   end

endmodule

>>> design/tama_merge.sv
`timescale 1ns / 1ps

module tama_merge (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   input  logic                               warm,
   input  logic signed [tama_pkg::SUM_W-1:0]  sum_x,
   input  logic signed [tama_pkg::SUM_W-1:0]  sum_y,
   input  logic signed [tama_pkg::SUM_W-1:0]  sum_z,
   input  logic                               out_stall,
   output logic                               out_valid,
   output logic                               in_stall,
   output tama_pkg::result_type               result
);
   import tama_pkg::*;

   result_type word_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   logic       pop;

   // zero the means until a full window has been seen
   always_comb begin
      word_in.mean_valid = warm;
      word_in.mean_x     = warm ? MEAN_W'(sum_x) : '0;
      word_in.mean_y     = warm ? MEAN_W'(sum_y) : '0;
      word_in.mean_z     = warm ? MEAN_W'(sum_z) : '0;
   end

   assign pop = out_valid_ff && !out_stall;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = word_in;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_in       = word_in;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign in_stall  = skid_valid_ff;
   assign result    = out_ff;

endmodule

>>> design/three_axis_moving_average.sv
`timescale 1ns / 1ps

// Three-axis boxcar moving average. Each input word carries one signed 16-bit
// sample per axis; each accepted word gives exactly one result word holding
// the window sums of the last WINDOW samples (the average with log2(WINDOW)
// fraction bits) for x, y and z, and mean_valid. Until WINDOW words have
// been taken in since reset, mean_valid is 0 and the means read as zero.
// Throughput is one word per clock while req_stall is low; ring read and sum
// update in each axis lane are combinational, and each result is registered
// in the output buffer. A two-entry output buffer keeps taking words while a
// result waits, and stalls the input only once both entries are full. Reset
// clears sums, write pointer and warm-up flag; the rings need no clearing
// pass, since entries not yet written read as zero until the pointer first
// wraps.

module three_axis_moving_average (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [tama_pkg::SAMPLE_W-1:0]   req_sample_x,
   input  logic signed [tama_pkg::SAMPLE_W-1:0]   req_sample_y,
   input  logic signed [tama_pkg::SAMPLE_W-1:0]   req_sample_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [tama_pkg::MEAN_W-1:0]     rsp_mean_x,
   output logic signed [tama_pkg::MEAN_W-1:0]     rsp_mean_y,
   output logic signed [tama_pkg::MEAN_W-1:0]     rsp_mean_z,
   output logic                                   rsp_mean_valid
);
   import tama_pkg::*;
   `include "assert_macros.svh"

   ptr_type          ptr_ff, ptr_in;
   logic             warm_ff, warm_in;
   logic             accept;
   logic             wrap;
   lane_ctl_type     ctl;
   logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
   result_type       result;

   assign accept = req_valid && !req_stall;
   assign wrap   = (ptr_ff == PTR_W'(WINDOW - 1));

   // advance the shared write pointer, set warm-up on the first wrap
   always_comb begin
      ptr_in  = ptr_ff;
      warm_in = warm_ff;
      if (accept) begin
         ptr_in  = wrap ? '0 : ptr_ff + 1'b1;
         warm_in = warm_ff || wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         warm_ff <= 1'b0;
      end else begin
         ptr_ff  <= ptr_in;
         warm_ff <= warm_in;
      end
   end

   always_comb begin
      ctl.accept = accept;
      ctl.primed = warm_ff;
      ctl.ptr    = ptr_ff;
   end

   // one lane per axis, all driven from the same pointer
   tama_lane u_lane_x (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (req_sample_x),
      .sum_next (sum_x)
   );

   tama_lane u_lane_y (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (req_sample_y),
      .sum_next (sum_y)
   );

   tama_lane u_lane_z (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sample   (req_sample_z),
      .sum_next (sum_z)
   );

   // combine lane sums into the result word and buffer it
   tama_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .warm      (warm_in),
      .sum_x     (sum_x),
      .sum_y     (sum_y),
      .sum_z     (sum_z),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .in_stall  (req_stall),
      .result    (result)
   );

   assign rsp_mean_x     = result.mean_x;
   assign rsp_mean_y     = result.mean_y;
   assign rsp_mean_z     = result.mean_z;
   assign rsp_mean_valid = result.mean_valid;

   `ASSERT_CLK(a_stall_has_result, req_stall |-> rsp_valid, "input stalled with no result held")
   `ASSERT_CLK(a_warm_sticky, warm_ff |=> warm_ff, "warm-up flag dropped after being set")
   `ASSERT_CLK(a_ptr_range, ptr_ff <= PTR_W'(WINDOW - 1), "write pointer beyond window")
   `ASSERT_CLK(a_cold_zero, (rsp_valid && !rsp_mean_valid) |-> (rsp_mean_x == '0 && rsp_mean_y == '0 && rsp_mean_z == '0), "nonzero mean during warm-up")

endmodule
